// ===== rtl/ars_pkg.sv =====
// Package for the autorange resistance selector: field widths, scale constants
// and register reset values. No dependencies.
package ars_pkg;

    localparam int RANGE_COUNT = 8;
    localparam int REG_COUNT   = 7;

    localparam int IDX_W  = 3;
    localparam int ADC_W  = 15;
    localparam int REF_W  = 26;
    localparam int RES_W  = 31;
    localparam int DIST_W = 14;

    localparam logic [RES_W-1:0]  RMAX_RES   = 31'd1584000000;
    localparam logic [ADC_W-1:0]  FULL_SCALE = 15'd32736;
    localparam logic [ADC_W-1:0]  HALF_SCALE = 15'd16368;
    localparam logic [DIST_W-1:0] KEEP_LIMIT = 14'd16000;
    localparam logic [DIST_W-1:0] DIST_MAX   = 14'd16383;

    // Reference indexes of the parallel range
    localparam logic [IDX_W-1:0] REG_R2 = 3'd5;
    localparam logic [IDX_W-1:0] REG_R1 = 3'd6;

    typedef logic [REF_W-1:0] t_ref_arr [REG_COUNT];

    localparam t_ref_arr REF_RESET = '{
        26'd32032000, 26'd5273600, 26'd750880, 26'd108640,
        26'd16000, 26'd3520, 26'd1608
    };

endpackage

// ===== rtl/ars_if.sv =====
// Valid/ready channels of the autorange resistance selector: one for input items
// and one for result items. Depends on ars_pkg.
interface ars_in_if;
    logic                      valid;
    logic                      ready;
    logic [ars_pkg::IDX_W-1:0] range_index;
    logic [ars_pkg::ADC_W-1:0] supply_sum;
    logic [ars_pkg::ADC_W-1:0] second_ref_sum;
    logic [ars_pkg::ADC_W-1:0] probe_sum;

    modport source (output valid, range_index, supply_sum, second_ref_sum, probe_sum,
                    input ready);
    modport sink (input valid, range_index, supply_sum, second_ref_sum, probe_sum,
                  output ready);
endinterface

interface ars_out_if;
    logic                       valid;
    logic                       ready;
    logic [ars_pkg::RES_W-1:0]  best_resistance;
    logic [ars_pkg::IDX_W-1:0]  best_range;
    logic [ars_pkg::DIST_W-1:0] best_distance;
    logic                       over_range;

    modport source (output valid, best_resistance, best_range, best_distance, over_range,
                    input ready);
    modport sink (input valid, best_resistance, best_range, best_distance, over_range,
                  output ready);
endinterface

// ===== rtl/autorange_resistance_select_core.sv =====
// Autorange resistance selector core: per-range resistance computation with one
// shared multiplier and a restoring divider, plus best-reading selection.
// Depends on ars_pkg and the channel interfaces in ars_if.sv.

// An item is accepted only while the block is idle. A single-reference range
// (0 to 6) keeps the block busy after acceptance, so the next item is taken only
// once the last is through: the shared 21x27 multiplier, one range check, 31
// steps of the restoring divider, which sets the latency and is skipped when the
// reading saturates, and an update of the kept reading. The parallel range (7)
// takes six multiplier passes for its numerator and denominator and one accumulate,
// the range check, the 31 divider steps, the update and a hand-over of the kept
// result to the output register that waits while that register still holds an
// earlier result that is not taken. The result register sits on the output, so the
// next sweep may start while a result waits. Configuration writes land in one cycle
// and must come while the block is idle.
module autorange_resistance_select_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ars_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [ars_pkg::REF_W-1:0]   i_cfg_data,
    ars_in_if.sink                      i_item,
    ars_out_if.source                   o_result
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_state;

    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 27;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NUM_W   = 67;
    localparam int DEN_W   = 44;
    localparam int REM_W   = DEN_W - 1;
    localparam int QHI_W   = NUM_W - ars_pkg::RES_W;

    localparam logic [2:0] LAST_STEP_PAR = 3'd6;
    localparam logic [2:0] LAST_STEP_SGL = 3'd1;
    localparam logic [4:0] DIV_LAST      = 5'(ars_pkg::RES_W - 1);
    localparam logic [4:0] LAST_RANGE    = 5'(ars_pkg::RANGE_COUNT - 1);

    t_state r_state, n_state;

    logic [ars_pkg::REF_W-1:0] r_ref [ars_pkg::REG_COUNT];

    logic [ars_pkg::IDX_W-1:0]  r_idx;
    logic                       r_par;
    logic [ars_pkg::ADC_W-1:0]  r_ux, r_u1, r_u2;
    logic [ars_pkg::REF_W-1:0]  r_rref;
    logic [MUL_B_W-1:0]         r_rsum;
    logic [ars_pkg::DIST_W-1:0] r_dist;
    logic [2:0]                 r_step;
    logic [4:0]                 r_cnt;
    logic [PROD_W-1:0]          r_prod;
    logic [40:0]                r_tmp;
    logic [NUM_W-1:0]           r_num;
    logic signed [DEN_W-1:0]    r_den;
    logic [REM_W-1:0]           r_rem;
    logic [ars_pkg::RES_W-1:0]  r_q;

    logic [ars_pkg::RES_W-1:0]  r_kept_res;
    logic [ars_pkg::DIST_W-1:0] r_kept_dist;
    logic [ars_pkg::IDX_W-1:0]  r_kept_range;

    logic                       r_out_valid;
    logic [ars_pkg::RES_W-1:0]  r_out_res;
    logic [ars_pkg::IDX_W-1:0]  r_out_range;
    logic [ars_pkg::DIST_W-1:0] r_out_dist;
    logic                       r_out_over;

    // accept-side decode
    logic                      in_fire;
    logic                      in_last;
    logic                      in_used;
    logic [ars_pkg::ADC_W-1:0] u0_eff;
    logic [ars_pkg::ADC_W-1:0] diff;
    logic [ars_pkg::DIST_W-1:0] in_dist;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    // divider
    logic [QHI_W-1:0]  num_hi;
    logic              den_pos;
    logic              quo_big;
    logic [REM_W:0]    div_t;
    logic [REM_W:0]    den_u;
    logic              div_ge;
    logic [REM_W:0]    div_sub;
    logic [ars_pkg::RES_W-1:0] res_sat;
    logic              out_free;
    logic              mul_done;

    assign i_item.ready = (r_state == ST_IDLE);
    assign in_fire      = i_item.valid && i_item.ready;
    assign in_last      = ({2'b00, i_item.range_index} == LAST_RANGE);
    assign in_used      = (32'(i_item.range_index) < ars_pkg::RANGE_COUNT)
                          && (in_last || (32'(i_item.range_index) < ars_pkg::REG_COUNT));
    assign u0_eff       = (i_item.range_index < 3'd2) ? ars_pkg::FULL_SCALE
                                                      : i_item.supply_sum;
    assign diff = (i_item.probe_sum >= ars_pkg::HALF_SCALE)
                  ? (i_item.probe_sum - ars_pkg::HALF_SCALE)
                  : (ars_pkg::HALF_SCALE - i_item.probe_sum);
    assign in_dist = (diff > 15'(ars_pkg::DIST_MAX)) ? ars_pkg::DIST_MAX
                                                     : diff[ars_pkg::DIST_W-1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_par) begin
            case (r_step)
                3'd0: begin
                    mul_a = MUL_A_W'(r_ux);
                    mul_b = MUL_B_W'(r_ref[ars_pkg::REG_R1]);
                end
                3'd1: begin
                    mul_a = MUL_A_W'(r_u1);
                    mul_b = MUL_B_W'(r_ref[ars_pkg::REG_R2]);
                end
                3'd2: begin
                    mul_a = MUL_A_W'(r_u2);
                    mul_b = MUL_B_W'(r_ref[ars_pkg::REG_R1]);
                end
                3'd3: begin
                    mul_a = MUL_A_W'(r_ux);
                    mul_b = r_rsum;
                end
                3'd4: begin
                    mul_a = r_tmp[20:0];
                    mul_b = MUL_B_W'(r_ref[ars_pkg::REG_R2]);
                end
                3'd5: begin
                    mul_a = {1'b0, r_tmp[40:21]};
                    mul_b = MUL_B_W'(r_ref[ars_pkg::REG_R2]);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else begin
            mul_a = MUL_A_W'(r_ux);
            mul_b = MUL_B_W'(r_rref);
        end
    end

    assign mul_done = r_par ? (r_step == LAST_STEP_PAR) : (r_step == LAST_STEP_SGL);

    assign num_hi  = r_num[NUM_W-1:ars_pkg::RES_W];
    assign den_pos = !r_den[DEN_W-1] && (r_den != '0);
    assign den_u   = {1'b0, r_den[REM_W-1:0]};
    assign quo_big = ({1'b0, (REM_W-QHI_W)'(0), num_hi} >= den_u);
    assign div_t   = {r_rem, r_num[ars_pkg::RES_W-1]};
    assign div_ge  = (div_t >= den_u);
    assign div_sub = div_t - den_u;
    assign res_sat = (r_q > ars_pkg::RMAX_RES) ? ars_pkg::RMAX_RES : r_q;
    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_fire && in_used) n_state = ST_MUL;
            ST_MUL:    if (mul_done) n_state = ST_CHECK;
            ST_CHECK:  n_state = (den_pos && !quo_big) ? ST_DIV : ST_UPDATE;
            ST_DIV:    if (r_cnt == DIV_LAST) n_state = ST_UPDATE;
            ST_UPDATE: n_state = r_par ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ars_pkg::REG_COUNT; i++) begin
                r_ref[i] <= ars_pkg::REF_RESET[i];
            end
        end else if (i_cfg_we && (32'(i_cfg_idx) < ars_pkg::REG_COUNT)) begin
            r_ref[i_cfg_idx] <= i_cfg_data;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ST_IDLE: begin
                r_step <= '0;
                r_cnt  <= '0;
                if (in_fire) begin
                    r_idx  <= i_item.range_index;
                    r_par  <= in_last;
                    r_ux   <= i_item.probe_sum;
                    r_u1   <= i_item.supply_sum;
                    r_u2   <= i_item.second_ref_sum;
                    r_rref <= (32'(i_item.range_index) < ars_pkg::REG_COUNT)
                              ? r_ref[i_item.range_index] : '0;
                    r_rsum <= {1'b0, r_ref[ars_pkg::REG_R1]} + {1'b0, r_ref[ars_pkg::REG_R2]};
                    r_dist <= in_dist;
                    r_den  <= $signed({29'b0, u0_eff}) - $signed({29'b0, i_item.probe_sum});
                end
            end
            ST_MUL: begin
                r_step <= r_step + 3'd1;
                if (r_par) begin
                    case (r_step)
                        3'd1: r_tmp <= r_prod[40:0];
                        3'd2: r_den <= $signed({1'b0, r_prod[REM_W-1:0]});
                        3'd3: r_den <= r_den + $signed({1'b0, r_prod[REM_W-1:0]});
                        3'd4: r_den <= r_den - $signed({1'b0, r_prod[REM_W-1:0]});
                        3'd5: r_num <= NUM_W'(r_prod);
                        3'd6: r_num <= r_num + {r_prod[45:0], 21'b0};
                        default: r_tmp <= r_tmp;
                    endcase
                end else if (r_step == LAST_STEP_SGL) begin
                    r_num <= NUM_W'(r_prod);
                end
            end
            ST_CHECK: begin
                // saturate on a non-positive denominator or a quotient of 2^31 or more
                r_rem <= REM_W'(num_hi);
                r_q   <= ars_pkg::RMAX_RES;
            end
            ST_DIV: begin
                r_rem <= div_ge ? div_sub[REM_W-1:0] : div_t[REM_W-1:0];
                r_q   <= {r_q[ars_pkg::RES_W-2:0], div_ge};
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // kept reading of the sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_res   <= ars_pkg::RMAX_RES;
            r_kept_dist  <= ars_pkg::KEEP_LIMIT;
            r_kept_range <= '0;
        end else if (in_fire && in_used && (i_item.range_index == '0)) begin
            r_kept_res   <= ars_pkg::RMAX_RES;
            r_kept_dist  <= ars_pkg::KEEP_LIMIT;
            r_kept_range <= '0;
        end else if ((r_state == ST_UPDATE) && (r_dist <= r_kept_dist)) begin
            // a later equal distance wins
            r_kept_res   <= res_sat;
            r_kept_dist  <= r_dist;
            r_kept_range <= r_idx;
        end else if ((r_state == ST_EMIT) && out_free) begin
            r_kept_res   <= ars_pkg::RMAX_RES;
            r_kept_dist  <= ars_pkg::KEEP_LIMIT;
            r_kept_range <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            r_out_res   <= r_kept_res;
            r_out_range <= r_kept_range;
            r_out_dist  <= r_kept_dist;
            r_out_over  <= (r_kept_res == ars_pkg::RMAX_RES);
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.best_resistance = r_out_res;
    assign o_result.best_range      = r_out_range;
    assign o_result.best_distance   = r_out_dist;
    assign o_result.over_range      = r_out_over;

`ifndef SYNTH
    a_div_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (!r_den[DEN_W-1] && (r_den != '0)))
        else $error("divider running on a non-positive denominator");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> ({1'b0, r_rem} < den_u))
        else $error("partial remainder not below denominator");

    a_kept_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_dist <= ars_pkg::KEEP_LIMIT)
        else $error("kept distance above keep limit");

    a_kept_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_res <= ars_pkg::RMAX_RES)
        else $error("kept resistance above saturation value");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result item raised outside the emit step");
`endif

endmodule
